### rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/tpsm_pkg.sv
// Package of the trie pattern matcher: defaults, codes, state and command types.
// Depends on nothing; used by the controller, the datapath, the top level and the testbench.
package tpsm_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int MAX_LEN_DEF   = 255;
    localparam int ALPHABET      = 84;
    localparam int SYM_W         = 7;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_REJECT  = 3'd1,
        ST_FULL    = 3'd2,
        ST_MATCH   = 3'd3,
        ST_NOMATCH = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_I_HEAD_A, S_I_HEAD_B, S_I_VAL_A, S_I_VAL_B,
        S_I_CNT_A, S_I_CNT_B, S_I_CNT_C, S_I_CNT_D, S_I_CHK,
        S_I_WR_A, S_I_WR_B, S_I_WR_C, S_I_WR_D,
        S_M_SCAN_A, S_M_SCAN_B, S_M_LEN, S_M_POS,
        S_M_WALK_A, S_M_WALK_B, S_M_WALK_C, S_M_WALK_D
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_HEAD, OP_NEXT, OP_CNT_INIT, OP_SYM, OP_MISS,
        OP_DESCEND, OP_WR_INIT, OP_LINK, OP_TERM, OP_MLEN, OP_POS_INIT,
        OP_WALK_INIT, OP_POS_NEXT
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    load;
        logic    fin;
        t_status code;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic ovf;
        logic plen_bad;
        logic sym_bad;
        logic at_end;
        logic one_char;
        logic cnt_last;
        logic child_zero;
        logic full;
        logic zero_byte;
        logic scan_last;
        logic mlen_bad;
        logic pos_ok;
        logic walk_end;
        logic hit;
        logic hit_ok;
    } t_dpst;

    typedef struct packed {
        logic             ok;
        logic [SYM_W-1:0] code;
    } t_sym;

    function automatic t_sym sym_of(input logic [7:0] c);
        t_sym r;
        r.ok   = 1'b1;
        r.code = '0;
        case (c) inside
            8'h21:          r.code = 7'd0;
            [8'h23:8'h39]:  r.code = SYM_W'(c - 8'h23 + 8'd1);
            [8'h3D:8'h5D]:  r.code = SYM_W'(c - 8'h3D + 8'd25);
            8'h5F:          r.code = 7'd57;
            [8'h61:8'h7A]:  r.code = SYM_W'(c - 8'h61 + 8'd58);
            default:        r.ok = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### rtl/tpsm_ram.sv
// Generic single write port RAM with one registered read port.
// No dependencies; used for the trie store and the character buffer.
module tpsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/tpsm_ctrl.sv
// Controller state machine of the trie matcher: load, clear, insert and match steps.
// Depends on tpsm_pkg; drives tpsm_dp through command and status structs.
module tpsm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_req_type,
    input  logic           i_last_char,
    input  tpsm_pkg::t_dpst i_st,
    output tpsm_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import tpsm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_cmd.load  = 1'b0;
        o_cmd.fin   = 1'b0;
        o_cmd.code  = ST_ADDED;
        o_busy      = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_char) n_state = i_req_type ? S_M_SCAN_A : S_I_HEAD_A;
                end
            end
            S_I_HEAD_A: begin
                if (i_st.ovf) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = ST_REJECT;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_I_HEAD_B;
                end
            end
            S_I_HEAD_B: begin
                o_cmd.op = OP_HEAD;
                if (i_st.plen_bad) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = ST_REJECT;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_I_VAL_A;
                end
            end
            S_I_VAL_A: n_state = S_I_VAL_B;
            S_I_VAL_B: begin
                if (i_st.sym_bad) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = ST_REJECT;
                    n_state    = S_IDLE;
                end else if (i_st.at_end) begin
                    o_cmd.op = OP_CNT_INIT;
                    n_state  = i_st.one_char ? S_I_CHK : S_I_CNT_A;
                end else begin
                    o_cmd.op = OP_NEXT;
                    n_state  = S_I_VAL_A;
                end
            end
            S_I_CNT_A: n_state = S_I_CNT_B;
            S_I_CNT_B: begin
                o_cmd.op = OP_SYM;
                n_state  = S_I_CNT_C;
            end
            S_I_CNT_C: n_state = S_I_CNT_D;
            S_I_CNT_D: begin
                if (i_st.child_zero) begin
                    o_cmd.op = OP_MISS;
                    n_state  = S_I_CHK;
                end else begin
                    o_cmd.op = OP_DESCEND;
                    n_state  = i_st.cnt_last ? S_I_CHK : S_I_CNT_A;
                end
            end
            S_I_CHK: begin
                if (i_st.full) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = ST_FULL;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.op = OP_WR_INIT;
                    n_state  = S_I_WR_A;
                end
            end
            S_I_WR_A: n_state = S_I_WR_B;
            S_I_WR_B: begin
                o_cmd.op = OP_SYM;
                n_state  = S_I_WR_C;
            end
            S_I_WR_C: n_state = S_I_WR_D;
            S_I_WR_D: begin
                if (i_st.at_end) begin
                    o_cmd.op   = OP_TERM;
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = ST_ADDED;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.op = i_st.child_zero ? OP_LINK : OP_DESCEND;
                    n_state  = S_I_WR_A;
                end
            end
            S_M_SCAN_A: begin
                if (i_st.ovf) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = ST_NOMATCH;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_M_SCAN_B;
                end
            end
            S_M_SCAN_B: begin
                if (i_st.zero_byte || i_st.scan_last) begin
                    o_cmd.op = OP_MLEN;
                    n_state  = S_M_LEN;
                end else begin
                    o_cmd.op = OP_NEXT;
                    n_state  = S_M_SCAN_A;
                end
            end
            S_M_LEN: begin
                if (i_st.mlen_bad) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = ST_NOMATCH;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.op = OP_POS_INIT;
                    n_state  = S_M_POS;
                end
            end
            S_M_POS: begin
                if (i_st.pos_ok) begin
                    o_cmd.op = OP_WALK_INIT;
                    n_state  = S_M_WALK_A;
                end else begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = ST_NOMATCH;
                    n_state    = S_IDLE;
                end
            end
            S_M_WALK_A: begin
                if (i_st.walk_end) begin
                    o_cmd.op = OP_POS_NEXT;
                    n_state  = S_M_POS;
                end else begin
                    n_state = S_M_WALK_B;
                end
            end
            S_M_WALK_B: begin
                if (i_st.sym_bad) begin
                    o_cmd.op = OP_POS_NEXT;
                    n_state  = S_M_POS;
                end else begin
                    o_cmd.op = OP_SYM;
                    n_state  = S_M_WALK_C;
                end
            end
            S_M_WALK_C: n_state = S_M_WALK_D;
            S_M_WALK_D: begin
                if (i_st.hit) begin
                    o_cmd.fin  = 1'b1;
                    o_cmd.code = i_st.hit_ok ? ST_MATCH : ST_NOMATCH;
                    n_state    = S_IDLE;
                end else if (i_st.child_zero) begin
                    o_cmd.op = OP_POS_NEXT;
                    n_state  = S_M_POS;
                end else begin
                    o_cmd.op = OP_DESCEND;
                    n_state  = S_M_WALK_A;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### rtl/tpsm_dp.sv
// Datapath of the trie matcher: buffer, trie store, walk registers and result register.
// Depends on tpsm_pkg and tpsm_ram; steered by tpsm_ctrl.
module tpsm_dp #(
    parameter int MAX_NODES = tpsm_pkg::MAX_NODES_DEF,
    parameter int MAX_LEN   = tpsm_pkg::MAX_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpsm_pkg::t_cmd   i_cmd,
    input  logic [7:0]       i_char_code,
    input  logic [8:0]       i_method_mask,
    output tpsm_pkg::t_dpst  o_st,
    output logic             o_valid,
    output logic [2:0]       o_status
);
    import tpsm_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int CW    = $clog2(MAX_NODES + 1);
    localparam int LW    = $clog2(MAX_LEN + 2);
    localparam int BUF_D = MAX_LEN + 1;
    localparam int BAW   = $clog2(BUF_D);
    localparam int STO_D = MAX_NODES * ALPHABET;
    localparam int SAW   = $clog2(STO_D);
    localparam int SLW   = NW + 11;
    localparam int FW    = ((CW > LW) ? CW : LW) + 1;

    logic [LW-1:0]    r_len, r_end, r_start, r_i, r_needed, r_mlen, r_pos, r_short;
    logic             r_ovf, r_anchor, r_valid;
    logic [CW-1:0]    r_ncount;
    logic [NW-1:0]    r_node;
    logic [SYM_W-1:0] r_sym;
    logic [8:0]       r_mask;
    logic [SAW-1:0]   r_clr;
    t_status          r_status;

    logic [7:0]       buf_q;
    logic [SLW-1:0]   slot_q, slot_w;
    logic [SAW-1:0]   slot_addr;
    logic             buf_we, sto_we, caret;
    logic [LW-1:0]    plen_new, plen;
    t_sym             sym_q;
    logic [NW-1:0]    child;

    assign buf_we    = i_cmd.load && (r_len < LW'(BUF_D));
    assign slot_addr = SAW'(r_node) * SAW'(ALPHABET) + SAW'(r_sym);
    assign sym_q     = sym_of(buf_q);
    assign caret     = (buf_q == CH_CARET);
    assign plen_new  = r_len - LW'(caret);
    assign plen      = r_end - r_start + LW'(1);
    assign child     = slot_q[NW-1:0];

    always_comb begin
        slot_w = slot_q;
        sto_we = 1'b0;
        case (i_cmd.op)
            OP_CLEAR: begin
                slot_w = '0;
                sto_we = 1'b1;
            end
            OP_LINK: begin
                slot_w[NW-1:0] = r_ncount[NW-1:0];
                sto_we = 1'b1;
            end
            OP_TERM: begin
                slot_w[NW+8:NW] = slot_q[NW+8:NW] | r_mask;
                slot_w[NW+9]    = slot_q[NW+9] | r_anchor;
                slot_w[NW+10]   = 1'b1;
                sto_we = 1'b1;
            end
            default: ;
        endcase
    end

    tpsm_ram #(.WIDTH(8), .DEPTH(BUF_D)) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_len[BAW-1:0]),
        .i_wdata (i_char_code),
        .i_raddr (r_i[BAW-1:0]),
        .o_rdata (buf_q)
    );

    tpsm_ram #(.WIDTH(SLW), .DEPTH(STO_D)) u_store (
        .i_clk   (i_clk),
        .i_we    (sto_we),
        .i_waddr ((i_cmd.op == OP_CLEAR) ? r_clr : slot_addr),
        .i_wdata (slot_w),
        .i_raddr (slot_addr),
        .o_rdata (slot_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_ncount <= CW'(1);
            r_short  <= '1;
            r_valid  <= 1'b0;
            r_clr    <= '0;
        end else begin
            r_valid <= i_cmd.fin;
            if (i_cmd.load) begin
                if (buf_we) r_len <= r_len + LW'(1);
                else        r_ovf <= 1'b1;
            end
            if (i_cmd.fin) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLEAR: r_clr    <= r_clr + SAW'(1);
                OP_LINK:  r_ncount <= r_ncount + CW'(1);
                OP_TERM:  if (plen < r_short) r_short <= plen;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mask <= i_method_mask;
            r_i    <= '0;
        end
        if (i_cmd.fin) r_status <= i_cmd.code;
        case (i_cmd.op)
            OP_HEAD: begin
                r_anchor <= caret;
                r_start  <= LW'(caret);
                r_end    <= r_len - LW'(1);
                r_i      <= LW'(caret);
            end
            OP_NEXT: r_i <= r_i + LW'(1);
            OP_CNT_INIT: begin
                r_i      <= r_start;
                r_node   <= '0;
                r_needed <= '0;
            end
            OP_SYM:  r_sym <= sym_q.code;
            OP_MISS: r_needed <= r_end - r_i;
            OP_DESCEND: begin
                r_node <= child;
                r_i    <= r_i + LW'(1);
            end
            OP_WR_INIT: begin
                r_i    <= r_start;
                r_node <= '0;
            end
            OP_LINK: begin
                r_node <= r_ncount[NW-1:0];
                r_i    <= r_i + LW'(1);
            end
            OP_MLEN:     r_mlen <= (buf_q == 8'h00) ? r_i : r_len;
            OP_POS_INIT: r_pos <= '0;
            OP_WALK_INIT: begin
                r_node <= '0;
                r_i    <= r_pos;
            end
            OP_POS_NEXT: r_pos <= r_pos + LW'(1);
            default: ;
        endcase
    end

    always_comb begin
        o_st.clr_last   = (r_clr == SAW'(STO_D - 1));
        o_st.ovf        = r_ovf;
        o_st.plen_bad   = (plen_new == '0) || (plen_new > LW'(MAX_LEN));
        o_st.sym_bad    = !sym_q.ok;
        o_st.at_end     = (r_i == r_end);
        o_st.one_char   = (r_start == r_end);
        o_st.cnt_last   = ((r_i + LW'(1)) == r_end);
        o_st.child_zero = (child == '0);
        o_st.full       = (FW'(r_ncount) + FW'(r_needed)) > FW'(MAX_NODES);
        o_st.zero_byte  = (buf_q == 8'h00);
        o_st.scan_last  = ((r_i + LW'(1)) == r_len);
        o_st.mlen_bad   = (r_mlen == '0) || (r_mlen > LW'(MAX_LEN));
        o_st.pos_ok     = (r_pos < r_mlen) && ((r_mlen - r_pos) >= r_short);
        o_st.walk_end   = (r_i == r_mlen);
        o_st.hit        = slot_q[NW+10] && ((slot_q[NW+8:NW] & r_mask) != 9'd0);
        o_st.hit_ok     = !slot_q[NW+9] || (r_pos == '0);
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
endmodule

### rtl/trie_pattern_substring_matcher.sv
// Top level of the trie pattern matcher: joins the controller and the datapath.
// Depends on tpsm_pkg, tpsm_ctrl, tpsm_dp and tpsm_ram.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------------
//  item in  | i_start, o_busy     | i_req_type, i_char_code, i_method_mask, i_last_char
//  result   | o_valid (one cycle) | o_status
//
// An item without the last-character mark leaves the block idle, ready for the next item.
// On the last character the block stays busy for the trie walk: an insert runs a
// validation pass over the buffer, then a path count pass and a write pass, in which
// each step reads the buffer, then the store; a match walks the trie per start position.
// After reset a clearing pass first zeroes all MAX_NODES*84 store slots (21504 default).
// The result strobe cannot be stalled; the next item may be accepted while it shows.
module trie_pattern_substring_matcher #(
    parameter int MAX_NODES = tpsm_pkg::MAX_NODES_DEF,
    parameter int MAX_LEN   = tpsm_pkg::MAX_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic       i_req_type,
    input  logic [7:0] i_char_code,
    input  logic [8:0] i_method_mask,
    input  logic       i_last_char,
    output logic       o_valid,
    output logic [2:0] o_status
);
    import tpsm_pkg::*;

    t_cmd  cmd;
    t_dpst st;

    tpsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req_type  (i_req_type),
        .i_last_char (i_last_char),
        .i_st        (st),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    tpsm_dp #(.MAX_NODES(MAX_NODES), .MAX_LEN(MAX_LEN)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_char_code   (i_char_code),
        .i_method_mask (i_method_mask),
        .o_st          (st),
        .o_valid       (o_valid),
        .o_status      (o_status)
    );
endmodule

### rtl/tpsm_checker.sv
// Port checker of the trie matcher, bound to the top level.
// Depends on assert_macros.svh; watches the top-level ports only.
`include "assert_macros.svh"

module tpsm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       i_req_type,
    input logic [7:0] i_char_code,
    input logic [8:0] i_method_mask,
    input logic       i_last_char,
    input logic       o_valid,
    input logic [2:0] o_status
);
    `ASSERT_CLK(a_status_code, i_clk, i_rst_n, o_valid |-> (o_status <= 3'd4), "bad status")
    `ASSERT_CLK(a_strobe_once, i_clk, i_rst_n, o_valid |=> !o_valid, "strobe too long")
    `ASSERT_CLK(a_after_work, i_clk, i_rst_n, o_valid |-> $past(o_busy), "result without work")
    `ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> (o_busy && !o_valid), "no clear pass")
endmodule

bind trie_pattern_substring_matcher tpsm_checker u_tpsm_checker (.*);

### tb/trie_pattern_substring_matcher_tb.sv
// Self-checking testbench of the trie pattern substring matcher.
// Depends on tpsm_pkg and trie_pattern_substring_matcher; predicts each status
// from its own trie model and compares every result strobe against it.
`timescale 1ns / 1ps

module trie_pattern_substring_matcher_tb;
    import tpsm_pkg::*;

    localparam int NODES      = 256;
    localparam int DEPTH      = NODES * 84;
    localparam int BUF_LEN    = 256;
    localparam int CYCLE_MAX  = 4000000;
    localparam int ITEM_GOAL  = 750;
    localparam int LONG_ITEMS = 523;
    localparam logic        TYPE_PAT  = 1'b0;
    localparam logic        TYPE_SUBJ = 1'b1;
    localparam logic [31:0] F_BEGIN   = 32'h2000_0000;
    localparam logic [31:0] F_TERM    = 32'h8000_0000;
    localparam logic [31:0] F_CHILD   = 32'h000F_FFFF;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    logic       i_req_type;
    logic [7:0] i_char_code;
    logic [8:0] i_method_mask;
    logic       i_last_char;
    logic       o_valid;
    logic [2:0] o_status;

    logic [31:0] trie_mem [DEPTH];
    logic [7:0]  text_buf [BUF_LEN];
    int          used_nodes;
    int          min_pat_len;
    int          text_len;
    logic        text_ovf;

    t_status status_q[$];
    int      errors;
    int      items_sent;
    int      results_seen;
    int      patterns_added;
    int      matches_seen;
    int      cycles;
    bit      no_gaps;

    trie_pattern_substring_matcher u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_req_type   (i_req_type),
        .i_char_code  (i_char_code),
        .i_method_mask(i_method_mask),
        .i_last_char  (i_last_char),
        .o_valid      (o_valid),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int symbol(input logic [7:0] c);
        if (c == 8'h21) return 0;
        if (c >= 8'h23 && c <= 8'h39) return int'(c) - 8'h23 + 1;
        if (c >= 8'h3D && c <= 8'h5D) return int'(c) - 8'h3D + 25;
        if (c == 8'h5F) return 57;
        if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 8'h61 + 58;
        return -1;
    endfunction

    function automatic logic [31:0] slot_rd(input int node, input int sym);
        int idx;
        idx = node * 84 + sym;
        return (idx < DEPTH) ? trie_mem[idx] : 32'h0;
    endfunction

    function automatic t_status insert_pattern(input logic [8:0] mask);
        int          first;
        int          len;
        int          node;
        int          needed;
        int          sym;
        logic [31:0] flags;
        logic [31:0] s;
        first = 0;
        len   = text_len;
        if (text_ovf) return ST_REJECT;
        flags = F_TERM | (32'(mask) << 20);
        if (len > 0 && text_buf[0] == CH_CARET) begin
            flags |= F_BEGIN;
            first = 1;
            len--;
        end
        if (len == 0 || len > 255) return ST_REJECT;
        for (int i = first; i < first + len; i++)
            if (symbol(text_buf[i]) < 0) return ST_REJECT;
        node   = 0;
        needed = 0;
        for (int i = first; i + 1 < first + len; i++) begin
            s = slot_rd(node, symbol(text_buf[i]));
            if ((s & F_CHILD) == 0) begin
                needed = first + len - 1 - i;
                break;
            end
            node = int'(s & F_CHILD);
        end
        if (used_nodes + needed > NODES) return ST_FULL;
        node = 0;
        for (int i = first; i < first + len; i++) begin
            sym = symbol(text_buf[i]);
            if (i + 1 == first + len) begin
                if (node * 84 + sym < DEPTH) trie_mem[node * 84 + sym] |= flags;
                break;
            end
            s = slot_rd(node, sym);
            if ((s & F_CHILD) == 0) begin
                if (node * 84 + sym < DEPTH)
                    trie_mem[node * 84 + sym] |= 32'(used_nodes) & F_CHILD;
                node = used_nodes;
                used_nodes++;
            end else begin
                node = int'(s & F_CHILD);
            end
        end
        if (len < min_pat_len) min_pat_len = len;
        return ST_ADDED;
    endfunction

    function automatic t_status match_subject(input logic [8:0] mask);
        int          len;
        int          node;
        int          sym;
        logic [31:0] want;
        logic [31:0] s;
        len = 0;
        if (text_ovf) return ST_NOMATCH;
        while (len < text_len && text_buf[len] != 8'h00) len++;
        if (len == 0 || len > 255) return ST_NOMATCH;
        want = 32'(mask) << 20;
        for (int pos = 0; pos < len && len - pos >= min_pat_len; pos++) begin
            node = 0;
            for (int p = pos; p < len; p++) begin
                sym = symbol(text_buf[p]);
                if (sym < 0) break;
                s = slot_rd(node, sym);
                if ((s & F_TERM) != 0 && (s & want) != 0)
                    return ((s & F_BEGIN) == 0 || pos == 0) ? ST_MATCH : ST_NOMATCH;
                if ((s & F_CHILD) == 0) break;
                node = int'(s & F_CHILD);
            end
        end
        return ST_NOMATCH;
    endfunction

    task automatic predict_status(input logic typ, input logic [7:0] ch,
                                  input logic [8:0] mask, input logic last);
        t_status st;
        if (text_len < BUF_LEN) begin
            text_buf[text_len] = ch;
            text_len++;
        end else begin
            text_ovf = 1'b1;
        end
        if (last) begin
            st = typ ? match_subject(mask) : insert_pattern(mask);
            if (st == ST_ADDED) patterns_added++;
            text_len = 0;
            text_ovf = 1'b0;
            status_q.push_back(st);
        end
    endtask

    task automatic send_item(input logic typ, input logic [7:0] ch,
                             input logic [8:0] mask, input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_req_type    <= typ;
        i_char_code   <= ch;
        i_method_mask <= mask;
        i_last_char   <= last;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        items_sent++;
        predict_status(typ, ch, mask, last);
    endtask

    task automatic send_word(input logic typ, input string s, input logic [8:0] mask);
        for (int i = 0; i < s.len() - 1; i++)
            send_item(typ, s[i], 9'($urandom_range(0, 511)), 1'b0);
        send_item(typ, s[s.len() - 1], mask, 1'b1);
    endtask

    task automatic test_empty_trie();
        send_word(TYPE_SUBJ, "abc", 9'h001);
    endtask

    task automatic test_pattern_checks();
        send_word(TYPE_PAT, "^", 9'h1FF);
        send_word(TYPE_PAT, "a b", 9'h1FF);
        send_item(TYPE_PAT, 8'hFF, 9'h1FF, 1'b1);
        send_word(TYPE_PAT, "abc", 9'h001);
        send_word(TYPE_PAT, "^fo", 9'h100);
        send_word(TYPE_PAT, "]", 9'h1FF);
    endtask

    task automatic test_match_cases();
        send_word(TYPE_SUBJ, "xabcx", 9'h001);
        send_word(TYPE_SUBJ, "xabcx", 9'h002);
        send_word(TYPE_SUBJ, "xabc", 9'h000);
        send_word(TYPE_SUBJ, "fo", 9'h100);
        send_word(TYPE_SUBJ, "xfo", 9'h100);
        send_word(TYPE_SUBJ, "_", 9'h080);
        send_item(TYPE_SUBJ, 8'h00, 9'h001, 1'b1);
        send_item(TYPE_PAT, 8'h61, 9'h000, 1'b0);
        send_item(TYPE_SUBJ, 8'h00, 9'h001, 1'b1);
    endtask

    task automatic test_random_traffic();
        string pool;
        int    len;
        logic  typ;
        logic  t;
        logic [7:0] ch;
        logic [8:0] mask;
        pool = "abc^]_!z9#";
        while (items_sent < ITEM_GOAL - LONG_ITEMS) begin
            if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
            typ = 1'($urandom_range(0, 1));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20)
                                              : $urandom_range(1, typ ? 10 : 5);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) < 8) ch = pool[$urandom_range(0, 9)];
                else ch = 8'($urandom_range(0, 255));
                t = ($urandom_range(0, 19) == 0) ? ~typ : typ;
                if (i == len - 1) begin
                    case ($urandom_range(0, 3))
                        0:       mask = 9'($urandom_range(0, 511));
                        1:       mask = ($urandom_range(0, 9) == 0) ? 9'h000 : 9'h1FF;
                        default: mask = 9'h001 << $urandom_range(0, 8);
                    endcase
                    send_item(typ, ch, mask, 1'b1);
                end else begin
                    send_item(t, ch, 9'($urandom_range(0, 511)), 1'b0);
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_long_strings();
        for (int i = 0; i < 257; i++)
            send_item(TYPE_SUBJ, 8'h61, 9'h1FF, i == 256);
        send_item(TYPE_PAT, CH_CARET, 9'h1FF, 1'b0);
        for (int i = 0; i < 255; i++)
            send_item(TYPE_PAT, 8'h62, 9'h1FF, i == 254);
        send_word(TYPE_PAT, "zz9z", 9'h004);
        send_word(TYPE_SUBJ, "azz9zb", 9'h004);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (status_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, o_status);
            end else begin
                if (o_status != status_q[0]) begin
                    errors++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, status_q[0], o_status);
                end
                if (o_status == ST_MATCH) matches_seen++;
                void'(status_q.pop_front());
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_req_type = 1'b0;
        i_char_code = '0;
        i_method_mask = '0;
        i_last_char = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        patterns_added = 0;
        matches_seen = 0;
        cycles = 0;
        no_gaps = 1'b0;
        foreach (trie_mem[i]) trie_mem[i] = '0;
        foreach (text_buf[i]) text_buf[i] = '0;
        used_nodes = 1;
        min_pat_len = 65535;
        text_len = 0;
        text_ovf = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_trie();
        test_pattern_checks();
        test_match_cases();
        test_random_traffic();
        test_long_strings();

        i_start <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d items, checked %0d results: %0d patterns added, %0d matches.",
                 items_sent, results_seen, patterns_added, matches_seen);
        $display("Trie ended with %0d of %0d nodes in use.", used_nodes, NODES);
        if (errors == 0 && status_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tpsm_pkg.sv
rtl/tpsm_ram.sv
rtl/tpsm_ctrl.sv
rtl/tpsm_dp.sv
rtl/trie_pattern_substring_matcher.sv
rtl/tpsm_checker.sv
tb/trie_pattern_substring_matcher_tb.sv
